[src/ldh_pkg.sv]
`default_nettype none

package ldh_pkg;

   localparam int CSR_IDX_BITS = 1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_EVENT = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STABILIZE = 1'd1;

   localparam logic [31:0] MIN_EVENT_RESET = 32'd3000;
   localparam logic [31:0] STABILIZE_RESET = 32'd0;

   localparam logic MODE_DETECT = 1'b0;
   localparam logic MODE_SWEEP  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DET,
      ST_SWEEP,
      ST_FLUSH
   } state_type;

endpackage

`default_nettype wire

[src/label_event_debounce_hold.sv]
// Per-label debounce with hold timer. A detection word (mode 0) of an
// inactive label starts its pending time if none is pending and raises the
// label once it has been present for stabilize_time_ms; every detection
// refreshes the label's last-seen time. A sweep word (mode 1) lowers every
// active label not seen for more than min_event_duration_ms, one result
// word per change in ascending label order, the final one marked last; a
// sweep without changes returns one empty word. Pending and last-seen
// times live in two one-port-read RAMs; flags are flip-flops. A detection
// reads the RAM, then updates; a sweep is accepted, reads the RAM once per
// label, checks the final label and then sends the final word. Either one
// can also be held while a stalled result word blocks it. Detections of
// labels not below LABELS are dropped without a result.
`default_nettype none

module label_event_debounce_hold #(
   parameter int LABELS    = 16,
   parameter int TIME_BITS = 48
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_mode,
   input  wire logic [3:0]                       req_label,
   input  wire logic [TIME_BITS-1:0]             req_now_ms,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_event_valid,
   output logic [3:0]                            rsp_event_label,
   output logic                                  rsp_level,
   output logic                                  rsp_last,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [ldh_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [31:0]                      csr_data
);

   import ldh_pkg::*;

   localparam int LW = $clog2(LABELS);

   state_type state_ff, state_in;

   logic [31:0]          min_ff, stab_ff;
   logic [LW-1:0]        idx_ff, idx_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [LABELS-1:0]    active_ff, active_in;
   logic [LABELS-1:0]    pvalid_ff, pvalid_in;
   logic [LABELS-1:0]    svalid_ff, svalid_in;
   logic [LW:0]          rd_cnt_ff, rd_cnt_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic [LW-1:0]        chk_idx_ff, chk_idx_in;
   logic                 hold_vld_ff, hold_vld_in;
   logic [LW-1:0]        hold_idx_ff, hold_idx_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_evv_ff, rsp_lvl_ff, rsp_last_ff;
   logic [3:0]           rsp_lab_ff;

   logic                 push, push_evv, push_lvl, push_last;
   logic [3:0]           push_lab;

   logic                 pend_wr, pend_rd, seen_wr, seen_rd;
   logic [LW-1:0]        pend_rd_addr, seen_rd_addr;
   logic [TIME_BITS-1:0] pend_rdata, seen_rdata;

   logic                 req_accept, out_free, in_range;
   logic [TIME_BITS-1:0] since;
   logic [TIME_BITS:0]   pend_diff, seen_diff;
   logic                 stab_ok, raise, chk_lower, blocked;

   ldh_ram #(.WIDTH(TIME_BITS), .DEPTH(LABELS)) u_pend_ram (
      .clock   (clock),
      .wr_en   (pend_wr),
      .wr_addr (idx_ff),
      .wr_data (now_ff),
      .rd_en   (pend_rd),
      .rd_addr (pend_rd_addr),
      .rd_data (pend_rdata)
   );

   ldh_ram #(.WIDTH(TIME_BITS), .DEPTH(LABELS)) u_seen_ram (
      .clock   (clock),
      .wr_en   (seen_wr),
      .wr_addr (idx_ff),
      .wr_data (now_ff),
      .rd_en   (seen_rd),
      .rd_addr (seen_rd_addr),
      .rd_data (seen_rdata)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign in_range   = (32'(req_label) < LABELS);
   assign csr_ready  = 1'b1;

   // saturating elapsed time checks
   assign since     = pvalid_ff[idx_ff] ? pend_rdata : now_ff;
   assign pend_diff = {1'b0, now_ff} - {1'b0, since};
   assign stab_ok   = pend_diff[TIME_BITS] ? (stab_ff == 32'd0)
                                           : (pend_diff[TIME_BITS-1:0] >= TIME_BITS'(stab_ff));
   assign raise     = !active_ff[idx_ff] && stab_ok;

   assign seen_diff = {1'b0, now_ff} - {1'b0, seen_rdata};
   assign chk_lower = chk_vld_ff && svalid_ff[chk_idx_ff] && active_ff[chk_idx_ff] &&
                      !seen_diff[TIME_BITS] &&
                      (seen_diff[TIME_BITS-1:0] > TIME_BITS'(min_ff));
   assign blocked   = chk_lower && hold_vld_ff && !out_free;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      now_in       = now_ff;
      active_in    = active_ff;
      pvalid_in    = pvalid_ff;
      svalid_in    = svalid_ff;
      rd_cnt_in    = rd_cnt_ff;
      chk_vld_in   = chk_vld_ff;
      chk_idx_in   = chk_idx_ff;
      hold_vld_in  = hold_vld_ff;
      hold_idx_in  = hold_idx_ff;
      push         = 1'b0;
      push_evv     = 1'b0;
      push_lab     = 4'd0;
      push_lvl     = 1'b0;
      push_last    = 1'b0;
      pend_wr      = 1'b0;
      pend_rd      = 1'b0;
      pend_rd_addr = LW'(req_label);
      seen_wr      = 1'b0;
      seen_rd      = 1'b0;
      seen_rd_addr = rd_cnt_ff[LW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               now_in = req_now_ms;
               idx_in = LW'(req_label);
               if (req_mode == MODE_SWEEP) begin
                  rd_cnt_in   = '0;
                  chk_vld_in  = 1'b0;
                  hold_vld_in = 1'b0;
                  state_in    = ST_SWEEP;
               end else if (in_range) begin
                  pend_rd  = 1'b1;
                  state_in = ST_DET;
               end
            end
         end
         ST_DET: begin
            if (!raise || out_free) begin
               if (!active_ff[idx_ff] && !pvalid_ff[idx_ff]) begin
                  pend_wr = 1'b1;
               end
               if (raise) begin
                  active_in[idx_ff] = 1'b1;
                  pvalid_in[idx_ff] = 1'b0;
                  push      = 1'b1;
                  push_evv  = 1'b1;
                  push_lab  = 4'(idx_ff);
                  push_lvl  = 1'b1;
                  push_last = 1'b1;
               end else if (!active_ff[idx_ff]) begin
                  pvalid_in[idx_ff] = 1'b1;
               end
               seen_wr           = 1'b1;
               svalid_in[idx_ff] = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            if (!blocked) begin
               if (chk_lower) begin
                  active_in[chk_idx_ff] = 1'b0;
                  if (hold_vld_ff) begin
                     push     = 1'b1;
                     push_evv = 1'b1;
                     push_lab = 4'(hold_idx_ff);
                  end
                  hold_vld_in = 1'b1;
                  hold_idx_in = chk_idx_ff;
               end
               if (rd_cnt_ff != (LW+1)'(LABELS)) begin
                  seen_rd    = 1'b1;
                  chk_vld_in = 1'b1;
                  chk_idx_in = rd_cnt_ff[LW-1:0];
                  rd_cnt_in  = rd_cnt_ff + 1'b1;
               end else begin
                  chk_vld_in = 1'b0;
                  state_in   = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               push      = 1'b1;
               push_evv  = hold_vld_ff;
               push_lab  = hold_vld_ff ? 4'(hold_idx_ff) : 4'd0;
               push_last = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (push) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_ff       <= MIN_EVENT_RESET;
         stab_ff      <= STABILIZE_RESET;
         active_ff    <= '0;
         pvalid_ff    <= '0;
         svalid_ff    <= '0;
         rd_cnt_ff    <= '0;
         chk_vld_ff   <= 1'b0;
         hold_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         pvalid_ff    <= pvalid_in;
         svalid_ff    <= svalid_in;
         rd_cnt_ff    <= rd_cnt_in;
         chk_vld_ff   <= chk_vld_in;
         hold_vld_ff  <= hold_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_MIN_EVENT: min_ff  <= csr_data;
               CSR_STABILIZE: stab_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      now_ff      <= now_in;
      chk_idx_ff  <= chk_idx_in;
      hold_idx_ff <= hold_idx_in;
      if (push) begin
         rsp_evv_ff  <= push_evv;
         rsp_lab_ff  <= push_lab;
         rsp_lvl_ff  <= push_lvl;
         rsp_last_ff <= push_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_valid = rsp_evv_ff;
   assign rsp_event_label = rsp_lab_ff;
   assign rsp_level       = rsp_lvl_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

`default_nettype wire

[src/ldh_ram.sv]
`default_nettype none

module ldh_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
   import ldh_pkg::*;

   localparam int LABELS      = 16;
   localparam int TIME_BITS   = 48;
   localparam int SETTLE_CYC  = 40;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic       ev_valid;
      logic [3:0] ev_label;
      logic       level;
      logic       last;
   } event_word_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_mode = MODE_DETECT;
   logic [3:0]              req_label = '0;
   logic [TIME_BITS-1:0]    req_now_ms = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_event_valid;
   logic [3:0]              rsp_event_label;
   logic                    rsp_level;
   logic                    rsp_last;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = CSR_MIN_EVENT;
   logic [31:0]             csr_data = '0;

   // predictor state
   logic [31:0]          hold_min_ms = MIN_EVENT_RESET;
   logic [31:0]          stable_ms   = STABILIZE_RESET;
   logic                 lbl_active[LABELS] = '{default: 1'b0};
   logic                 pend_valid[LABELS] = '{default: 1'b0};
   logic [TIME_BITS-1:0] pend_since[LABELS] = '{default: '0};
   logic                 seen_valid[LABELS] = '{default: 1'b0};
   logic [TIME_BITS-1:0] seen_at[LABELS]    = '{default: '0};

   event_word_type expected_events[$];
   event_word_type want;
   int             mismatches = 0;
   int             cycle_count = 0;
   int             stall_pct = 0;
   int             stall_hold = 0;
   int             gap_pct = 0;

   label_event_debounce_hold #(
      .LABELS   (LABELS),
      .TIME_BITS(TIME_BITS)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_label      (req_label),
      .req_now_ms     (req_now_ms),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_event_valid(rsp_event_valid),
      .rsp_event_label(rsp_event_label),
      .rsp_level      (rsp_level),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [TIME_BITS-1:0] age_ms(logic [TIME_BITS-1:0] now,
                                                   logic [TIME_BITS-1:0] then);
      return (now >= then) ? now - then : '0;
   endfunction

   function automatic void predict_events(logic mode, logic [3:0] label,
                                          logic [TIME_BITS-1:0] now);
      event_word_type ev;
      int             first;
      first = expected_events.size();
      if (mode == MODE_DETECT) begin
         if (!lbl_active[label]) begin
            if (!pend_valid[label]) begin
               pend_valid[label] = 1'b1;
               pend_since[label] = now;
            end
            if (age_ms(now, pend_since[label]) >= TIME_BITS'(stable_ms)) begin
               lbl_active[label] = 1'b1;
               pend_valid[label] = 1'b0;
               expected_events.push_back('{1'b1, label, 1'b1, 1'b1});
            end
         end
         seen_valid[label] = 1'b1;
         seen_at[label]    = now;
      end else begin
         for (int i = 0; i < LABELS; i++) begin
            if (seen_valid[i] && lbl_active[i] &&
                age_ms(now, seen_at[i]) > TIME_BITS'(hold_min_ms)) begin
               lbl_active[i] = 1'b0;
               expected_events.push_back('{1'b1, 4'(i), 1'b0, 1'b0});
            end
         end
         if (expected_events.size() == first) begin
            expected_events.push_back('{1'b0, 4'd0, 1'b0, 1'b1});
         end else begin
            ev = expected_events.pop_back();
            ev.last = 1'b1;
            expected_events.push_back(ev);
         end
      end
   endfunction

   task automatic send_word(logic mode, logic [3:0] label, logic [TIME_BITS-1:0] now);
      int gap;
      gap = 0;
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_mode   <= mode;
      req_label  <= label;
      req_now_ms <= now;
      do @(posedge clock); while (req_stall);
      predict_events(mode, label, now);
   endtask

   task automatic write_csr(logic [CSR_IDX_BITS-1:0] idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_MIN_EVENT) begin
         hold_min_ms = data;
      end else begin
         stable_ms = data;
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_setting();
      case ($urandom_range(0, 4))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return 32'($urandom_range(1, 50));
         3: return 32'($urandom_range(100, 5000));
         default: return $urandom;
      endcase
   endfunction

   // reset values: hold 3000 ms, no stabilize time
   task automatic test_defaults();
      send_word(MODE_DETECT, 4'd0, 48'd0);
      send_word(MODE_DETECT, 4'd0, 48'd100);
      send_word(MODE_SWEEP, 4'd0, 48'd3100);
      send_word(MODE_DETECT, 4'd5, 48'd3100);
      send_word(MODE_DETECT, 4'd15, 48'd3100);
      send_word(MODE_SWEEP, 4'd7, 48'd6101);
      send_word(MODE_SWEEP, 4'd0, 48'd6101);
   endtask

   // pending time, stale pending time, time going backwards
   task automatic test_pending();
      settle();
      write_csr(CSR_STABILIZE, 32'd100);
      send_word(MODE_DETECT, 4'd3, 48'd1000);
      send_word(MODE_DETECT, 4'd3, 48'd1099);
      send_word(MODE_DETECT, 4'd3, 48'd1100);
      send_word(MODE_DETECT, 4'd4, 48'd2000);
      send_word(MODE_DETECT, 4'd4, 48'd9000);
      send_word(MODE_DETECT, 4'd6, 48'd5000);
      send_word(MODE_DETECT, 4'd6, 48'd4000);
   endtask

   task automatic test_extremes();
      settle();
      stall_pct = 30;
      gap_pct   = 30;
      write_csr(CSR_MIN_EVENT, 32'd0);
      write_csr(CSR_STABILIZE, 32'hFFFF_FFFF);
      send_word(MODE_DETECT, 4'd9, 48'd0);
      send_word(MODE_DETECT, 4'd9, 48'h0_FFFF_FFFE);
      send_word(MODE_DETECT, 4'd9, 48'h0_FFFF_FFFF);
      send_word(MODE_SWEEP, 4'hF, 48'h0_FFFF_FFFF);
      send_word(MODE_SWEEP, 4'd0, 48'hFFFF_FFFF_FFFF);
      settle();
      write_csr(CSR_MIN_EVENT, 32'hFFFF_FFFF);
      write_csr(CSR_STABILIZE, 32'd0);
      send_word(MODE_DETECT, 4'd12, 48'hFFFF_FFFF_FFFF);
      send_word(MODE_SWEEP, 4'd0, 48'd0);
      send_word(MODE_DETECT, 4'd1, 48'd0);
      send_word(MODE_SWEEP, 4'd0, 48'h1_0000_0000);
   endtask

   // frames of detections closed by a sweep, plus some noise words
   task automatic test_random();
      logic [TIME_BITS-1:0] now_ms;
      logic [3:0]           label;
      int                   sent;
      int                   dets;
      for (int phase = 0; phase < 6; phase++) begin
         settle();
         write_csr(CSR_MIN_EVENT, pick_setting());
         write_csr(CSR_STABILIZE, pick_setting());
         stall_pct = (phase == 1) ? 0 : 10 * $urandom_range(1, 5);
         gap_pct   = (phase == 1) ? 0 : 10 * $urandom_range(1, 5);
         now_ms    = {16'($urandom), 32'($urandom)};
         sent      = 0;
         while (sent < 40) begin
            if ($urandom_range(0, 9) == 0) begin
               send_word(1'($urandom), 4'($urandom), {16'($urandom), 32'($urandom)});
               sent++;
            end else begin
               case ($urandom_range(0, 6))
                  0: now_ms = now_ms;
                  1: now_ms = now_ms + $urandom_range(1, 20);
                  2: now_ms = now_ms + stable_ms;
                  3: now_ms = now_ms + hold_min_ms;
                  4: now_ms = now_ms + hold_min_ms + 1;
                  5: now_ms = now_ms + $urandom;
                  default: now_ms = now_ms - $urandom_range(1, 50);
               endcase
               dets = $urandom_range(0, 4);
               repeat (dets) begin
                  label = $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'($urandom);
                  send_word(MODE_DETECT, label, now_ms);
                  sent++;
               end
               send_word(MODE_SWEEP, 4'($urandom), now_ms);
               sent++;
            end
         end
      end
   endtask

   function automatic void check_field(string name, logic [3:0] exp_v, logic [3:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_events.size() == 0) begin
            $display("%0t: unexpected word expected none actual %0h %0h %0h %0h", $time,
                     rsp_event_valid, rsp_event_label, rsp_level, rsp_last);
            mismatches++;
         end else begin
            want = expected_events.pop_front();
            check_field("event_valid", 4'(want.ev_valid), 4'(rsp_event_valid));
            check_field("event_label", want.ev_label, rsp_event_label);
            check_field("level", 4'(want.level), 4'(rsp_level));
            check_field("last", 4'(want.last), 4'(rsp_last));
         end
      end
   end

   // result side back-pressure: mostly short bursts, a few long
   always @(posedge clock) begin
      if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         rsp_stall  <= 1'b1;
         stall_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults();
      test_pending();
      test_extremes();
      test_random();
      settle();
      if (mismatches == 0 && expected_events.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
